// ===== src/mbde_pkg.sv =====
// Shared types, widths and constants of the Mandelbox distance estimator.
package mbde_pkg;

  localparam int FOLD_ITERATIONS = 10;

  localparam int PT_W   = 32;             // Q8.24 point / result words
  localparam int Z_W    = 48;             // Q24.24 iterate
  localparam int ZH_W   = Z_W / 2;        // half iterate for split multiplies
  localparam int DR_W   = 64;             // Q40.24 derivative
  localparam int DRH_W  = DR_W / 2;
  localparam int SC_W   = 29;             // scale register, signed Q4.24
  localparam int M_W    = 33;             // sphere factor, Q3.30 up to 4.0
  localparam int REC_W  = 32;             // reciprocal divisor
  localparam int TRAP_W = 32;
  localparam int LEN_W  = 48;             // floor(|z|)
  localparam int SQ_W   = 96;             // |z|^2

  localparam int SPH_SH = 30;             // Q3.30 factor shift
  localparam int SCL_SH = 24;             // Q.24 scale shift

  localparam int REC_STEPS = 3;
  localparam int REC_STG   = M_W / REC_STEPS;
  localparam int RT_STEPS  = 3;
  localparam int RT_STG    = LEN_W / RT_STEPS;
  localparam int DV_BITS   = 32;
  localparam int DV_STEPS  = 2;
  localparam int DV_STG    = DV_BITS / DV_STEPS;

  localparam logic [Z_W-1:0]   ZMAX_U   = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [DR_W-1:0]  ONE_DR   = 64'd16777216;
  localparam logic [M_W-1:0]   M_FOUR   = 33'h1_0000_0000;
  localparam logic [M_W-1:0]   M_UNIT   = 33'h0_4000_0000;
  localparam logic [REC_W-1:0] REC_REM0 = 32'h2000_0000;  // 2^62 >> 33
  localparam logic [SC_W-1:0]  SCALE_RST = 29'd40600663;

  typedef enum logic [1:0] {
    SPH_NONE,
    SPH_FOUR,
    SPH_RECIP
  } sph_t;

  typedef struct packed {
    logic [2:0][PT_W-1:0]   p;
    logic [2:0][Z_W-1:0]    z;
    logic [DR_W-1:0]        dr;
    logic [2:0][TRAP_W-1:0] trap;
  } core_t;

  typedef struct packed {
    logic [DR_W-1:0]        dr;
    logic [2:0][TRAP_W-1:0] trap;
  } tail_t;

  typedef struct packed {
    logic                   neg;
    logic [SC_W-1:0]        mag;
  } scl_t;

  typedef struct packed {
    logic [PT_W-1:0]        distance;
    logic [2:0][TRAP_W-1:0] trap;
  } res_t;

  function automatic logic [Z_W-1:0] zmag(input logic [Z_W-1:0] v);
    return v[Z_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== src/mbde_in_if.sv =====
// Point channel: valid/ready plus one query point word.
interface mbde_in_if import mbde_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== src/mbde_out_if.sv =====
// Result channel: valid/ready plus distance and orbit-trap word.
interface mbde_out_if import mbde_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PT_W-1:0] distance;
  logic [PT_W-1:0] trap_x;
  logic [PT_W-1:0] trap_y;
  logic [PT_W-1:0] trap_z;

  modport source (output valid, distance, trap_x, trap_y, trap_z, input ready);
  modport sink (input valid, distance, trap_x, trap_y, trap_z, output ready);
endinterface

// ===== src/mandelbox_distance_estimate.sv =====
// Pipe from point accept to result valid: 10 fold rounds of 19 stages (11 of them the
// reciprocal), 19 stages of |z|^2 and square root, 17 of quotient, 1 output register.
// Throughput: one point per cycle while the skid register is empty.
// Stall: the whole pipe freezes only when output and skid registers are both full.
// Reset (sync, rst_n low): all valid bits clear, scale_r returns to 2.42 (Q4.24).
module mandelbox_distance_estimate import mbde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mbde_in_if.sink               in_ch,
  mbde_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic signed [SC_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic [SC_W-1:0] scale_r;
  scl_t            scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // |scale| needs all 29 bits for the most negative code
  assign scale.neg = scale_r[SC_W-1];
  assign scale.mag = scale_r[SC_W-1] ? (~scale_r + 1'b1) : scale_r;

  // ---------------------------------------------------------------- flow
  // Pipe advances whenever the skid register is empty; the skid catches the
  // one word that leaves the pipe in the cycle the output stalls.
  logic en;
  logic out_v_r, skid_v_r, out_free;
  res_t out_r, skid_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign out_free    = !out_v_r || out_ch.ready;

  // ---------------------------------------------------------------- rounds
  logic  it_v [FOLD_ITERATIONS+1];
  core_t it_c [FOLD_ITERATIONS+1];

  // z starts at p, dr at 1.0, trap at "none yet"
  assign it_v[0]      = in_ch.valid;
  assign it_c[0].p    = {in_ch.point_z, in_ch.point_y, in_ch.point_x};
  assign it_c[0].z    = {Z_W'(in_ch.point_z), Z_W'(in_ch.point_y), Z_W'(in_ch.point_x)};
  assign it_c[0].dr   = ONE_DR;
  assign it_c[0].trap = '1;

  for (genvar i = 0; i < FOLD_ITERATIONS; i++) begin : g_round
    mbde_iter u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .scale (scale),
      .in_v  (it_v[i]),
      .in_c  (it_c[i]),
      .out_v (it_v[i+1]),
      .out_c (it_c[i+1])
    );
  end

  // ---------------------------------------------------------------- |z|
  logic             len_v;
  logic [LEN_W-1:0] len;
  tail_t            len_tail;

  mbde_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (it_v[FOLD_ITERATIONS]),
    .in_c     (it_c[FOLD_ITERATIONS]),
    .out_v    (len_v),
    .out_len  (len),
    .out_tail (len_tail)
  );

  // ---------------------------------------------------------------- |z| / dr
  logic pipe_v;
  res_t pipe_res;

  mbde_qdiv u_qdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (len_v),
    .in_len  (len),
    .in_tail (len_tail),
    .out_v   (pipe_v),
    .out_res (pipe_res)
  );

  // ---------------------------------------------------------------- output + skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (pipe_v) begin
      if (out_free) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_free) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (pipe_v) begin
      if (out_free) begin
        out_r <= pipe_res;
      end else begin
        skid_r <= pipe_res;
      end
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.distance = out_r.distance;
  assign out_ch.trap_x   = out_r.trap[0];
  assign out_ch.trap_y   = out_r.trap[1];
  assign out_ch.trap_z   = out_r.trap[2];

  // ---------------------------------------------------------------- checks
  // a held skid word always has an output word ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid full while output empty");

  // a word leaving the pipe into a stalled output must land in the skid
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_v && !skid_v_r && out_v_r && !out_ch.ready) |=> skid_v_r)
    else $error("pipe word dropped on output stall");

  // the skid word is held until the output frees up
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ch.ready) |=> skid_v_r)
    else $error("skid word lost while output stalled");

endmodule

// ===== src/mbde_iter.sv =====
// One fold round: box fold, sphere fold with pipelined reciprocal, scale and offset.
module mbde_iter import mbde_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  scl_t  scale,
  input  logic  in_v,
  input  core_t in_c,
  output logic  out_v,
  output core_t out_c
);

  localparam int R2_W = Z_W + 2;
  localparam int PS_W = ZH_W + M_W;
  localparam int PD_W = DRH_W + M_W;
  localparam int ZS_W = ZH_W + SC_W;
  localparam int DS_W = DRH_W + SC_W;
  localparam logic signed [Z_W:0] ONE_X = 49'sd16777216;
  localparam logic signed [Z_W:0] TWO_X = 49'sd33554432;

  // ---- box fold
  logic  v1_r, small1_r, small1_nxt;
  core_t c1_r, c1_nxt;

  always_comb begin
    logic signed [Z_W:0] zx;
    c1_nxt     = in_c;
    small1_nxt = 1'b1;
    for (int a = 0; a < 3; a++) begin
      zx = $signed({in_c.z[a][Z_W-1], in_c.z[a]});
      if (zx > ONE_X) begin
        zx = TWO_X - zx;
      end else if (zx < -ONE_X) begin
        zx = -TWO_X - zx;
      end
      c1_nxt.z[a] = zx[Z_W-1:0];
      if (!(zx > -ONE_X && zx < ONE_X)) begin
        small1_nxt = 1'b0;
      end
    end
  end

  // ---- squares of the small coordinates
  logic                v2_r, small2_r;
  core_t               c2_r;
  logic [2:0][Z_W-1:0] sq2_r, sq2_nxt;

  always_comb begin
    logic [Z_W-1:0] mz;
    for (int a = 0; a < 3; a++) begin
      mz = zmag(c1_r.z[a]);
      sq2_nxt[a] = Z_W'(mz[ZH_W-1:0]) * Z_W'(mz[ZH_W-1:0]);
    end
  end

  // ---- r2 and sphere mode
  logic             v3_r;
  core_t            c3_r;
  sph_t             mode3_r, mode3_nxt;
  logic [REC_W-1:0] d3_r, d3_nxt;

  always_comb begin
    logic [R2_W-1:0] r2;
    r2 = R2_W'(sq2_r[0]) + R2_W'(sq2_r[1]) + R2_W'(sq2_r[2]);
    d3_nxt = r2[2*ZH_W-1 -: REC_W];
    if (!small2_r) begin
      mode3_nxt = SPH_NONE;
    end else if (r2[R2_W-1:2*ZH_W-2] == '0) begin
      mode3_nxt = SPH_FOUR;
    end else if (r2[R2_W-1:2*ZH_W] == '0) begin
      mode3_nxt = SPH_RECIP;
    end else begin
      mode3_nxt = SPH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= c1_nxt;
      small1_r <= small1_nxt;
      c2_r     <= c1_r;
      small2_r <= small1_r;
      sq2_r    <= sq2_nxt;
      c3_r     <= c2_r;
      mode3_r  <= mode3_nxt;
      d3_r     <= d3_nxt;
    end
  end

  // ---- reciprocal 2^62 / d, restoring, REC_STEPS quotient bits per stage
  logic             dv_v_r   [REC_STG];
  core_t            dv_c_r   [REC_STG];
  sph_t             dv_m_r   [REC_STG];
  logic [REC_W-1:0] dv_d_r   [REC_STG];
  logic [REC_W-1:0] dv_rem_r [REC_STG];
  logic [M_W-1:0]   dv_q_r   [REC_STG];

  for (genvar k = 0; k < REC_STG; k++) begin : g_rec
    logic             sv;
    core_t            sc;
    sph_t             sm;
    logic [REC_W-1:0] sd, srem, rem_nxt;
    logic [M_W-1:0]   sq, q_nxt;

    if (k == 0) begin : g_head
      assign sv   = v3_r;
      assign sc   = c3_r;
      assign sm   = mode3_r;
      assign sd   = d3_r;
      assign srem = REC_REM0;
      assign sq   = '0;
    end else begin : g_body
      assign sv   = dv_v_r[k-1];
      assign sc   = dv_c_r[k-1];
      assign sm   = dv_m_r[k-1];
      assign sd   = dv_d_r[k-1];
      assign srem = dv_rem_r[k-1];
      assign sq   = dv_q_r[k-1];
    end

    always_comb begin
      logic [REC_W:0] t;
      rem_nxt = srem;
      q_nxt   = sq;
      for (int j = 0; j < REC_STEPS; j++) begin
        t = {rem_nxt, 1'b0};
        if (t >= {1'b0, sd}) begin
          t     = t - {1'b0, sd};
          q_nxt = {q_nxt[M_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[M_W-2:0], 1'b0};
        end
        rem_nxt = t[REC_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c_r[k]   <= sc;
        dv_m_r[k]   <= sm;
        dv_d_r[k]   <= sd;
        dv_rem_r[k] <= rem_nxt;
        dv_q_r[k]   <= q_nxt;
      end
    end
  end

  // ---- sphere products
  logic                 vm_r, foldm_r, foldm_nxt;
  core_t                cm_r;
  logic [2:0][PS_W-1:0] pzm_r, pzm_nxt;
  logic [PD_W-1:0]      pdlm_r, pdlm_nxt, pdhm_r, pdhm_nxt;

  always_comb begin
    logic [M_W-1:0] m;
    logic [Z_W-1:0] mz;
    core_t          c;
    c = dv_c_r[REC_STG-1];
    unique case (dv_m_r[REC_STG-1])
      SPH_FOUR:  m = M_FOUR;
      SPH_RECIP: m = dv_q_r[REC_STG-1];
      default:   m = M_UNIT;
    endcase
    foldm_nxt = (dv_m_r[REC_STG-1] != SPH_NONE);
    for (int a = 0; a < 3; a++) begin
      mz = zmag(c.z[a]);
      pzm_nxt[a] = PS_W'(mz[ZH_W-1:0]) * PS_W'(m);
    end
    pdlm_nxt = PD_W'(c.dr[DRH_W-1:0]) * PD_W'(m);
    pdhm_nxt = PD_W'(c.dr[DR_W-1:DRH_W]) * PD_W'(m);
  end

  // ---- sphere combine
  logic  vn_r;
  core_t cn_r, cn_nxt;

  always_comb begin
    logic [PD_W+DRH_W-1:0] full;
    logic [Z_W-1:0]        r;
    cn_nxt = cm_r;
    full = {pdhm_r, {DRH_W{1'b0}}} + (PD_W+DRH_W)'(pdlm_r);
    if (|full[PD_W+DRH_W-1:DR_W+SPH_SH]) begin
      cn_nxt.dr = '1;
    end else begin
      cn_nxt.dr = full[DR_W+SPH_SH-1:SPH_SH];
    end
    for (int a = 0; a < 3; a++) begin
      r = Z_W'(pzm_r[a][PS_W-1:SPH_SH]);
      if (foldm_r) begin
        cn_nxt.z[a] = cm_r.z[a][Z_W-1] ? (~r + 1'b1) : r;
      end
    end
  end

  // ---- scale products
  logic                 vs_r;
  core_t                cs_r;
  logic [2:0][ZS_W-1:0] pzl_r, pzl_nxt, pzh_r, pzh_nxt;
  logic [DS_W-1:0]      pdl_r, pdl_nxt, pdh_r, pdh_nxt;

  always_comb begin
    logic [Z_W-1:0] mz;
    for (int a = 0; a < 3; a++) begin
      mz = zmag(cn_r.z[a]);
      pzl_nxt[a] = ZS_W'(mz[ZH_W-1:0]) * ZS_W'(scale.mag);
      pzh_nxt[a] = ZS_W'(mz[Z_W-1:ZH_W]) * ZS_W'(scale.mag);
    end
    pdl_nxt = DS_W'(cn_r.dr[DRH_W-1:0]) * DS_W'(scale.mag);
    pdh_nxt = DS_W'(cn_r.dr[DR_W-1:DRH_W]) * DS_W'(scale.mag);
  end

  // ---- scale combine with saturation
  logic  vt_r;
  core_t ct_r, ct_nxt;

  always_comb begin
    logic [ZS_W:0]         r;
    logic [Z_W-1:0]        mg;
    logic [DS_W+DRH_W-1:0] full;
    ct_nxt = cs_r;
    for (int a = 0; a < 3; a++) begin
      r = (ZS_W+1)'(pzh_r[a]) + (ZS_W+1)'(pzl_r[a] >> ZH_W);
      if (r > (ZS_W+1)'(ZMAX_U)) begin
        mg = ZMAX_U;
      end else begin
        mg = r[Z_W-1:0];
      end
      ct_nxt.z[a] = (cs_r.z[a][Z_W-1] ^ scale.neg) ? (~mg + 1'b1) : mg;
    end
    full = {pdh_r, {DRH_W{1'b0}}} + (DS_W+DRH_W)'(pdl_r);
    if (|full[DS_W+DRH_W-1:DR_W+SCL_SH]) begin
      ct_nxt.dr = '1;
    end else begin
      ct_nxt.dr = full[DR_W+SCL_SH-1:SCL_SH];
    end
  end

  // ---- add point, clamp, trap, dr + 1
  logic  vu_r;
  core_t cu_r, cu_nxt;

  always_comb begin
    logic signed [Z_W:0] s;
    logic [Z_W-1:0]      zc, tm;
    logic [TRAP_W-1:0]   ts;
    cu_nxt = ct_r;
    for (int a = 0; a < 3; a++) begin
      s = $signed({ct_r.z[a][Z_W-1], ct_r.z[a]}) + (Z_W+1)'($signed(ct_r.p[a]));
      if (s[Z_W] != s[Z_W-1]) begin
        zc = s[Z_W] ? ~ZMAX_U : ZMAX_U;
      end else begin
        zc = s[Z_W-1:0];
      end
      cu_nxt.z[a] = zc;
      tm = zmag(zc);
      ts = (|tm[Z_W-1:TRAP_W]) ? '1 : tm[TRAP_W-1:0];
      if (ts < ct_r.trap[a]) begin
        cu_nxt.trap[a] = ts;
      end
    end
    if (&ct_r.dr[DR_W-1:SCL_SH]) begin
      cu_nxt.dr = '1;
    end else begin
      cu_nxt.dr = ct_r.dr + ONE_DR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vn_r <= 1'b0;
      vs_r <= 1'b0;
      vt_r <= 1'b0;
      vu_r <= 1'b0;
    end else if (en) begin
      vm_r <= dv_v_r[REC_STG-1];
      vn_r <= vm_r;
      vs_r <= vn_r;
      vt_r <= vs_r;
      vu_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r    <= dv_c_r[REC_STG-1];
      foldm_r <= foldm_nxt;
      pzm_r   <= pzm_nxt;
      pdlm_r  <= pdlm_nxt;
      pdhm_r  <= pdhm_nxt;
      cn_r    <= cn_nxt;
      cs_r    <= cn_r;
      pzl_r   <= pzl_nxt;
      pzh_r   <= pzh_nxt;
      pdl_r   <= pdl_nxt;
      pdh_r   <= pdh_nxt;
      ct_r    <= ct_nxt;
      cu_r    <= cu_nxt;
    end
  end

  assign out_v = vu_r;
  assign out_c = cu_r;

endmodule

// ===== src/mbde_isqrt.sv =====
// |z|^2 of the final iterate and its floored square root, digit-pair pipeline.
module mbde_isqrt import mbde_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  core_t            in_c,
  output logic             out_v,
  output logic [LEN_W-1:0] out_len,
  output tail_t            out_tail
);

  localparam int RM_W = LEN_W + 4;

  // ---- partial squares
  logic                v1_r;
  tail_t               t1_r;
  logic [2:0][Z_W-1:0] hh_r, hl_r, ll_r, hh_nxt, hl_nxt, ll_nxt;

  always_comb begin
    logic [Z_W-1:0] mz;
    for (int a = 0; a < 3; a++) begin
      mz = zmag(in_c.z[a]);
      hh_nxt[a] = Z_W'(mz[Z_W-1:ZH_W]) * Z_W'(mz[Z_W-1:ZH_W]);
      hl_nxt[a] = Z_W'(mz[Z_W-1:ZH_W]) * Z_W'(mz[ZH_W-1:0]);
      ll_nxt[a] = Z_W'(mz[ZH_W-1:0]) * Z_W'(mz[ZH_W-1:0]);
    end
  end

  // ---- per-axis squares
  logic                 v2_r;
  tail_t                t2_r;
  logic [2:0][SQ_W-1:0] sq2_r, sq2_nxt;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq2_nxt[a] = (SQ_W'(hh_r[a]) << (2*ZH_W)) + (SQ_W'(hl_r[a]) << (ZH_W+1))
                 + SQ_W'(ll_r[a]);
    end
  end

  // ---- total
  logic            v3_r;
  tail_t           t3_r;
  logic [SQ_W-1:0] s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= '{dr: in_c.dr, trap: in_c.trap};
      hh_r  <= hh_nxt;
      hl_r  <= hl_nxt;
      ll_r  <= ll_nxt;
      t2_r  <= t1_r;
      sq2_r <= sq2_nxt;
      t3_r  <= t2_r;
      s3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    end
  end

  // ---- root, RT_STEPS bits per stage
  logic             rt_v_r    [RT_STG];
  tail_t            rt_t_r    [RT_STG];
  logic [SQ_W-1:0]  rt_s_r    [RT_STG];
  logic [RM_W-1:0]  rt_rem_r  [RT_STG];
  logic [LEN_W-1:0] rt_root_r [RT_STG];

  for (genvar k = 0; k < RT_STG; k++) begin : g_root
    logic             sv;
    tail_t            st;
    logic [SQ_W-1:0]  ss, s_nxt;
    logic [RM_W-1:0]  srem, rem_nxt;
    logic [LEN_W-1:0] sroot, root_nxt;

    if (k == 0) begin : g_head
      assign sv    = v3_r;
      assign st    = t3_r;
      assign ss    = s3_r;
      assign srem  = '0;
      assign sroot = '0;
    end else begin : g_body
      assign sv    = rt_v_r[k-1];
      assign st    = rt_t_r[k-1];
      assign ss    = rt_s_r[k-1];
      assign srem  = rt_rem_r[k-1];
      assign sroot = rt_root_r[k-1];
    end

    always_comb begin
      logic [RM_W-1:0] trial;
      s_nxt    = ss;
      rem_nxt  = srem;
      root_nxt = sroot;
      for (int j = 0; j < RT_STEPS; j++) begin
        rem_nxt = {rem_nxt[RM_W-3:0], s_nxt[SQ_W-1:SQ_W-2]};
        s_nxt   = s_nxt << 2;
        trial   = {2'b00, root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[LEN_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[LEN_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[k] <= 1'b0;
      end else if (en) begin
        rt_v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_t_r[k]    <= st;
        rt_s_r[k]    <= s_nxt;
        rt_rem_r[k]  <= rem_nxt;
        rt_root_r[k] <= root_nxt;
      end
    end
  end

  assign out_v    = rt_v_r[RT_STG-1];
  assign out_len  = rt_root_r[RT_STG-1];
  assign out_tail = rt_t_r[RT_STG-1];

endmodule

// ===== src/mbde_qdiv.sv =====
// Saturating quotient len * 2^24 / dr, restoring, DV_STEPS bits per stage.
module mbde_qdiv import mbde_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [LEN_W-1:0] in_len,
  input  tail_t            in_tail,
  output logic             out_v,
  output res_t             out_res
);

  localparam int PRE_W = DV_BITS - SCL_SH;   // len bits that land in the quotient window

  // ---- overflow check and initial remainder
  logic               v0_r, sat0_r;
  tail_t              t0_r;
  logic [DR_W-1:0]    rem0_r;
  logic [DV_BITS-1:0] nb0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r   <= in_tail;
      sat0_r <= ((DR_W+PRE_W)'(in_len) >= {in_tail.dr, {PRE_W{1'b0}}});
      rem0_r <= DR_W'(in_len >> PRE_W);
      nb0_r  <= {in_len[PRE_W-1:0], {SCL_SH{1'b0}}};
    end
  end

  logic               dv_v_r   [DV_STG];
  logic               dv_sat_r [DV_STG];
  tail_t              dv_t_r   [DV_STG];
  logic [DR_W-1:0]    dv_rem_r [DV_STG];
  logic [DV_BITS-1:0] dv_nb_r  [DV_STG];
  logic [DV_BITS-1:0] dv_q_r   [DV_STG];

  for (genvar k = 0; k < DV_STG; k++) begin : g_div
    logic               sv, ssat;
    tail_t              st;
    logic [DR_W-1:0]    srem, rem_nxt;
    logic [DV_BITS-1:0] snb, nb_nxt, sq, q_nxt;

    if (k == 0) begin : g_head
      assign sv   = v0_r;
      assign ssat = sat0_r;
      assign st   = t0_r;
      assign srem = rem0_r;
      assign snb  = nb0_r;
      assign sq   = '0;
    end else begin : g_body
      assign sv   = dv_v_r[k-1];
      assign ssat = dv_sat_r[k-1];
      assign st   = dv_t_r[k-1];
      assign srem = dv_rem_r[k-1];
      assign snb  = dv_nb_r[k-1];
      assign sq   = dv_q_r[k-1];
    end

    always_comb begin
      logic [DR_W:0] t;
      rem_nxt = srem;
      nb_nxt  = snb;
      q_nxt   = sq;
      for (int j = 0; j < DV_STEPS; j++) begin
        t      = {rem_nxt, nb_nxt[DV_BITS-1]};
        nb_nxt = nb_nxt << 1;
        if (t >= {1'b0, st.dr}) begin
          t     = t - {1'b0, st.dr};
          q_nxt = {q_nxt[DV_BITS-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[DV_BITS-2:0], 1'b0};
        end
        rem_nxt = t[DR_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sat_r[k] <= ssat;
        dv_t_r[k]   <= st;
        dv_rem_r[k] <= rem_nxt;
        dv_nb_r[k]  <= nb_nxt;
        dv_q_r[k]   <= q_nxt;
      end
    end
  end

  assign out_v            = dv_v_r[DV_STG-1];
  assign out_res.distance = dv_sat_r[DV_STG-1] ? '1 : dv_q_r[DV_STG-1];
  assign out_res.trap     = dv_t_r[DV_STG-1].trap;

endmodule

// ===== tb/mbde_checker.sv =====
// Checker: predicts each distance/trap word from accepted points and compares results.
module mbde_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_distance,
  input  logic [31:0] out_trap_x,
  input  logic [31:0] out_trap_y,
  input  logic [31:0] out_trap_z,
  input  logic        cfg_we,
  input  logic [28:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE  = 64'd16777216;
  localparam longint ZMAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam longint ZMIN = -ZMAX - 1;

  typedef struct {
    logic [31:0] distance;
    logic [31:0] trap_x;
    logic [31:0] trap_y;
    logic [31:0] trap_z;
  } de_word_t;

  de_word_t    de_queue[$];
  logic [28:0] scale_reg;

  function automatic logic [63:0] absval(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b, int sh,
                                                logic [63:0] lim);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> sh;
    return (prod > {64'd0, lim}) ? lim : prod[63:0];
  endfunction

  function automatic longint signed_mul(longint v, logic [63:0] bm, bit bneg, int sh);
    logic [63:0] r;
    r = mul_shift_sat(absval(v), bm, sh, ZMAX);
    return ((v < 0) != bneg) ? -longint'(r) : longint'(r);
  endfunction

  function automatic de_word_t fold_estimate(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [28:0] sc_raw);
    longint       p[3];
    longint       z[3];
    logic [63:0]  trap[3];
    logic [63:0]  dr, scm, r2, m, len, q;
    logic [127:0] sq, cand;
    longint       sc, s;
    bit           scneg, near;
    de_word_t     w;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    sc = longint'($signed(sc_raw));
    scm = absval(sc);
    scneg = sc < 0;
    dr = ONE;
    for (int a = 0; a < 3; a++) begin
      z[a] = p[a];
      trap[a] = '1;
    end
    for (int it = 0; it < 10; it++) begin
      near = 1;
      // box fold
      for (int a = 0; a < 3; a++) begin
        if (z[a] > ONE) z[a] = 2 * ONE - z[a];
        else if (z[a] < -ONE) z[a] = -2 * ONE - z[a];
        if (absval(z[a]) >= ONE) near = 0;
      end
      // sphere fold only when every axis is below one
      if (near) begin
        r2 = 0;
        for (int a = 0; a < 3; a++) r2 += absval(z[a]) * absval(z[a]);
        if (r2 < (64'd1 << 46)) m = 64'd1 << 32;
        else if (r2 < (64'd1 << 48)) m = (64'd1 << 62) / (r2 >> 16);
        else m = 0;
        if (m != 0) begin
          for (int a = 0; a < 3; a++) z[a] = signed_mul(z[a], m, 0, 30);
          dr = mul_shift_sat(dr, m, 30, '1);
        end
      end
      for (int a = 0; a < 3; a++) begin
        s = signed_mul(z[a], scm, scneg, 24) + p[a];
        if (s > ZMAX) s = ZMAX;
        if (s < ZMIN) s = ZMIN;
        z[a] = s;
        if (absval(s) < trap[a]) trap[a] = absval(s);
      end
      dr = mul_shift_sat(dr, scm, 24, '1);
      dr = (dr > 64'hFFFF_FFFF_FFFF_FFFF - ONE) ? '1 : dr + ONE;
    end
    sq = 0;
    for (int a = 0; a < 3; a++) sq += {64'd0, absval(z[a])} * {64'd0, absval(z[a])};
    len = 0;
    for (int b = 47; b >= 0; b--) begin
      cand = {64'd0, len | (64'd1 << b)};
      if (cand * cand <= sq) len = cand[63:0];
    end
    q = 64'(({64'd0, len} << 24) / {64'd0, dr});
    w.distance = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    w.trap_x = (trap[0] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : trap[0][31:0];
    w.trap_y = (trap[1] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : trap[1][31:0];
    w.trap_z = (trap[2] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : trap[2][31:0];
    return w;
  endfunction

  assign pending = de_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    de_word_t want;
    if (!rst_n) begin
      scale_reg <= 29'd40600663;
      de_queue.delete();
    end else begin
      if (cfg_we) scale_reg <= cfg_wdata;
      if (in_valid && in_ready)
        de_queue.push_back(fold_estimate(in_x, in_y, in_z, scale_reg));
      if (out_valid && out_ready) begin
        if (de_queue.size() == 0) begin
          $error("unexpected result word distance=%h", out_distance);
          fail_count++;
        end else begin
          want = de_queue.pop_front();
          if (out_distance !== want.distance) begin
            $error("distance expected %h actual %h", want.distance, out_distance);
            fail_count++;
          end
          if (out_trap_x !== want.trap_x) begin
            $error("trap_x expected %h actual %h", want.trap_x, out_trap_x);
            fail_count++;
          end
          if (out_trap_y !== want.trap_y) begin
            $error("trap_y expected %h actual %h", want.trap_y, out_trap_y);
            fail_count++;
          end
          if (out_trap_z !== want.trap_z) begin
            $error("trap_z expected %h actual %h", want.trap_z, out_trap_z);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_mandelbox_distance_estimate.sv =====
// Top of the testbench: clock, reset, point and scale stimulus, final verdict.
module tb_mandelbox_distance_estimate;
  timeunit 1ns;
  timeprecision 1ps;
  import mbde_pkg::*;

  localparam int ONE_Q = 1 << 24;
  // pipe depth per the block header, plus margin
  localparam int DRAIN = 260;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic signed [SC_W-1:0] cfg_wdata = '0;
  bit   steady = 0;   // no idling on either side while set
  int   fail_count;
  int   pending;

  mbde_in_if  in_ch ();
  mbde_out_if out_ch ();

  always #2 clk = ~clk;

  mandelbox_distance_estimate DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  mbde_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_x(in_ch.point_x), .in_y(in_ch.point_y), .in_z(in_ch.point_z),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_distance(out_ch.distance), .out_trap_x(out_ch.trap_x),
    .out_trap_y(out_ch.trap_y), .out_trap_z(out_ch.trap_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 0;
  end

  // result side stalls about 22% of cycles unless steady
  always @(posedge clk) out_ch.ready <= steady || ($urandom_range(99) >= 22);

  // one point word; valid stays up between back-to-back words
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (!steady && $urandom_range(99) < 22) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid   <= 1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // scale writes only with the pipe empty
  task automatic load_scale(logic [SC_W-1:0] v);
    drain_pipe();
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 0;
  endtask

  // mostly coordinates near the fractal (|c| <= 3) so folds are exercised
  function automatic logic [31:0] pick_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(6 * ONE_Q) - 3 * ONE_Q;
    if (sel < 80) return $urandom_range(2 * ONE_Q) - ONE_Q;
    return $urandom;
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      send_point(pick_coord(), pick_coord(), pick_coord());
      // pressure: at the midpoint the sender may hold off once until every result is back
      if (i == n / 2 && $urandom_range(1)) drain_pipe();
    end
  endtask

  initial begin
    logic [SC_W-1:0] scales[8];
    scales = '{29'h1000_0000, 29'h0FFF_FFFF, 29'd0, 29'd16777216,
               29'h1E00_0000, 29'd33554432, 29'd40600663, 29'h0};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed words under the reset scale
    send_point(0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(ONE_Q, -ONE_Q, ONE_Q);
    send_point(ONE_Q + 1, -ONE_Q - 1, ONE_Q - 1);
    send_point(ONE_Q / 10, ONE_Q / 10, ONE_Q / 10);       // r2 under a quarter
    send_point(ONE_Q / 2, 0, 0);                          // r2 exactly a quarter
    send_point(ONE_Q * 7 / 10, ONE_Q / 2, ONE_Q / 5);     // reciprocal fold
    send_point(ONE_Q * 3 / 5, ONE_Q * 3 / 5, ONE_Q * 3 / 5); // r2 past one, no fold
    send_point(ONE_Q - 1, 0, 0);
    send_point(2 * ONE_Q, -2 * ONE_Q, 3 * ONE_Q);
    send_point(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    send_point(-(ONE_Q / 3), ONE_Q / 4, -(ONE_Q / 7));
    random_points(60);

    foreach (scales[k]) begin
      if (k == 7) scales[k] = SC_W'($urandom);
      load_scale(scales[k]);
      steady = (k == 3);
      if (k == 2) begin
        send_point(32'h7FFF_FFFF, 32'h8000_0000, ONE_Q);
        send_point(ONE_Q / 10, -(ONE_Q / 10), 0);
      end
      random_points(55);
    end
    steady = 0;

    drain_pipe();
    if (fail_count == 0) $display("mandelbox_distance_estimate verification clean");
    else $display("mandelbox_distance_estimate verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("mandelbox_distance_estimate verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
src/mbde_pkg.sv
src/mbde_in_if.sv
src/mbde_out_if.sv
src/mbde_iter.sv
src/mbde_isqrt.sv
src/mbde_qdiv.sv
src/mandelbox_distance_estimate.sv
tb/mbde_checker.sv
tb/tb_mandelbox_distance_estimate.sv
